// ===== hdl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_store, skt_cmp and sorted_key_table; no dependencies.
package skt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = 5;
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 64;
   localparam int KIND_W      = 2;
   localparam int STAT_W      = 2;
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_DATA_W  = 112;

   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_END   = 2'd3;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_res_type;

endpackage

// ===== hdl/sorted_key_table.sv =====
// Sorted key table top level: sequencer, entry count and result register.
// Depends on skt_pkg, skt_store and skt_cmp.
//
// Usage:
//   req channel carries one operation per transfer: tuser is the kind
//   (find, insert, read), tdata holds key, position and value.
//   rsp channel returns exactly one result per request: tuser is the
//   status, tdata holds found, slot index, key, value and entry count.
//   One request is in flight at a time; req_tready is high only while the
//   sequencer is idle, from the cycle after the result register loads.
// Handling, from request transfer to rsp_tvalid:
//   rejected insert, out-of-range read and unknown kind go straight to
//   the result; other reads first wait on the registered memory read.
//   find: one binary search step per probe, at most five steps with a
//   full table. insert: one entry move per cycle over the single memory
//   read and write port, then the new entry is written.
// The result register frees the sequencer as soon as it is loaded; a stall
// on rsp holds the result there and holds back only the next completion.
// Reset empties the table (count to zero) and drops any pending result.
module sorted_key_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] search_key, [36:32] position, [100:37] entry_value, rest zero
   input  logic [skt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] kind
   input  logic [skt_pkg::KIND_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] found, [5:1] slot_index, [37:6] read_key, [101:38] read_value,
   // [106:102] entry_count, rest zero
   output logic [skt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [1:0] status
   output logic [skt_pkg::STAT_W-1:0]         rsp_tuser
);
   import skt_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DISPATCH  = 3'd1;
   localparam logic [2:0] S_FIND_RD   = 3'd2;
   localparam logic [2:0] S_FIND_CMP  = 3'd3;
   localparam logic [2:0] S_SHIFT     = 3'd4;
   localparam logic [2:0] S_WRITE_NEW = 3'd5;
   localparam logic [2:0] S_READ_WAIT = 3'd6;
   localparam logic [2:0] S_RESULT    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, ptr_ff, ptr_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;

   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic              res_found_ff, res_found_in;
   logic [CNT_W-1:0]  res_slot_ff, res_slot_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [VAL_W-1:0]  res_val_ff, res_val_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]     rsp_user_ff, rsp_user_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   cmp_res_type       cmp_res;

   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  mid_calc, ptr_m1, ptr_m2, count_m1;
   logic              out_free, load_rsp;

   skt_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skt_cmp u_cmp (
      .key_a (key_ff),
      .key_b (rd_data.key),
      .res   (cmp_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc   = mid_sum[CNT_W:1];
   assign ptr_m1     = ptr_ff - CNT_W'(1);
   assign ptr_m2     = ptr_ff - CNT_W'(2);
   assign count_m1   = count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      ptr_in        = ptr_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;
      res_val_in    = res_val_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '{value: val_ff, key: key_ff};
      rd_addr       = '0;
      load_rsp      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               key_in   = req_tdata[31:0];
               pos_in   = req_tdata[36:32];
               val_in   = req_tdata[100:37];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_status_in = STAT_OK;
            res_found_in  = 1'b0;
            res_slot_in   = '0;
            res_key_in    = '0;
            res_val_in    = '0;
            case (kind_ff)
               KIND_FIND: begin
                  lo_in    = '0;
                  hi_in    = count_ff;
                  state_in = S_FIND_RD;
               end
               KIND_INSERT: begin
                  if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                     res_status_in = STAT_FULL;
                     state_in      = S_RESULT;
                  end else if (pos_ff > count_ff) begin
                     res_status_in = STAT_RANGE;
                     state_in      = S_RESULT;
                  end else if (pos_ff == count_ff) begin
                     state_in = S_WRITE_NEW;
                  end else begin
                     ptr_in   = count_ff;
                     rd_addr  = count_m1[IDX_W-1:0];
                     state_in = S_SHIFT;
                  end
               end
               KIND_READ: begin
                  if (pos_ff < count_ff) begin
                     rd_addr  = pos_ff[IDX_W-1:0];
                     state_in = S_READ_WAIT;
                  end else begin
                     res_status_in = STAT_END;
                     state_in      = S_RESULT;
                  end
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_FIND_RD: begin
            if (lo_ff == hi_ff) begin
               res_slot_in = lo_ff;
               state_in    = S_RESULT;
            end else begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc[IDX_W-1:0];
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (cmp_res.eq) begin
               res_found_in = 1'b1;
               res_slot_in  = mid_ff;
               state_in     = S_RESULT;
            end else if (cmp_res.lt) begin
               hi_in    = mid_ff;
               state_in = S_FIND_RD;
            end else begin
               lo_in    = mid_ff + CNT_W'(1);
               state_in = S_FIND_RD;
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[IDX_W-1:0];
            wr_data = rd_data;
            ptr_in  = ptr_m1;
            if (ptr_m1 == pos_ff) begin
               state_in = S_WRITE_NEW;
            end else begin
               rd_addr = ptr_m2[IDX_W-1:0];
            end
         end
         S_WRITE_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IDX_W-1:0];
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESULT;
         end
         S_READ_WAIT: begin
            res_key_in = rd_data.key;
            res_val_in = rd_data.value;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_status_ff;
         rsp_data_in  = {5'd0, count_ff, res_val_ff, res_key_ff, res_slot_ff, res_found_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      ptr_ff        <= ptr_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      res_key_ff    <= res_key_in;
      res_val_ff    <= res_val_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

// ===== hdl/skt_store.sv =====
// Entry memory: one write port and one registered read port.
// Depends on skt_pkg.
module skt_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [skt_pkg::IDX_W-1:0]     wr_addr,
   input  skt_pkg::entry_type            wr_data,
   input  logic [skt_pkg::IDX_W-1:0]     rd_addr,
   output skt_pkg::entry_type            rd_data
);
   import skt_pkg::*;

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/skt_cmp.sv =====
// Shared key comparator used by every binary search step.
// Depends on skt_pkg.
module skt_cmp (
   input  logic [skt_pkg::KEY_W-1:0] key_a,
   input  logic [skt_pkg::KEY_W-1:0] key_b,
   output skt_pkg::cmp_res_type      res
);
   import skt_pkg::*;

   always_comb begin
      res.eq = (key_a == key_b);
      res.lt = (key_a < key_b);
   end
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for sorted_key_table: find, insert, read and unused-kind traffic on the
// req stream, with each rsp transfer checked against an in-bench model of the sorted table.
// Depends on skt_pkg and the sorted_key_table RTL only.
module testbench;
   import skt_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 32;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              found;
      logic [CNT_W-1:0]  slot;
      logic [KEY_W-1:0]  rd_key;
      logic [VAL_W-1:0]  rd_value;
      logic [CNT_W-1:0]  entries;
   } result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   logic [KEY_W-1:0] tbl_key   [MAX_ENTRIES];
   logic [VAL_W-1:0] tbl_value [MAX_ENTRIES];
   int unsigned      tbl_count = 0;
   result_type       pending_q[$];

   int fail_count  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int n_find = 0, n_hit = 0, n_insert = 0, n_insert_ok = 0;
   int n_read = 0, n_read_end = 0, n_unused = 0;

   always #1 clock = ~clock;

   sorted_key_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic void search_keys(input logic [KEY_W-1:0] key, output logic hit,
                                       output int unsigned slot);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo  = 0;
      hi  = tbl_count;
      hit = 1'b0;
      while (lo != hi) begin
         mid = (lo + hi) / 2;
         if (key == tbl_key[mid]) begin
            hit  = 1'b1;
            slot = mid;
            return;
         end
         if (key < tbl_key[mid]) begin
            hi = mid;
         end else begin
            lo = mid + 1;
         end
      end
      slot = lo;
   endfunction

   function automatic result_type apply_op(input logic [KIND_W-1:0] kind,
                                           input logic [KEY_W-1:0] key,
                                           input logic [4:0] pos,
                                           input logic [VAL_W-1:0] value);
      result_type  res;
      logic        hit;
      int unsigned slot;
      res = '0;
      case (kind)
         KIND_FIND: begin
            search_keys(key, hit, slot);
            res.found = hit;
            res.slot  = slot[CNT_W-1:0];
         end
         KIND_INSERT: begin
            if (tbl_count >= MAX_ENTRIES) begin
               res.status = STAT_FULL;
            end else if (pos > tbl_count) begin
               res.status = STAT_RANGE;
            end else begin
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_key[i]   = tbl_key[i-1];
                  tbl_value[i] = tbl_value[i-1];
               end
               tbl_key[pos]   = key;
               tbl_value[pos] = value;
               tbl_count++;
            end
         end
         KIND_READ: begin
            if (pos < tbl_count) begin
               res.rd_key   = tbl_key[pos];
               res.rd_value = tbl_value[pos];
            end else begin
               res.status = STAT_END;
            end
         end
         default: ;
      endcase
      res.entries = tbl_count[CNT_W-1:0];
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] key;
      key = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: if (tbl_count > 0) key = tbl_key[$urandom_range(0, tbl_count - 1)];
         3:       if (tbl_count > 0) key = tbl_key[$urandom_range(0, tbl_count - 1)] + 1'b1;
         4:       if (tbl_count > 0) key = tbl_key[$urandom_range(0, tbl_count - 1)] - 1'b1;
         5:       key = '0;
         6:       key = '1;
         default: ;
      endcase
      return key;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                       input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                          input logic [4:0] pos, input logic [VAL_W-1:0] value);
      result_type res;
      int         gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({value, pos, key});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = apply_op(kind, key, pos, value);
      pending_q.push_back(res);
      burst_left--;
      case (kind)
         KIND_FIND: begin
            n_find++;
            n_hit += res.found;
         end
         KIND_INSERT: begin
            n_insert++;
            n_insert_ok += (res.status == STAT_OK);
         end
         KIND_READ: begin
            n_read++;
            n_read_end += (res.status == STAT_END);
         end
         default: n_unused++;
      endcase
   endtask

   // hold off new requests until every outstanding result has come back
   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic random_op(input int insert_pct);
      int unsigned      roll;
      int unsigned      slot;
      logic             hit;
      logic [KEY_W-1:0] key;
      logic [4:0]       pos;
      roll = $urandom_range(0, 99);
      key  = pick_key();
      pos  = 5'($urandom_range(0, 31));
      if (roll < insert_pct) begin
         case ($urandom_range(0, 9))
            0: ;
            1: pos = 5'($urandom_range(0, tbl_count));
            default: begin
               search_keys(key, hit, slot);
               pos = slot[4:0];
            end
         endcase
         send_op(KIND_INSERT, key, pos, pick_value());
      end else if (roll < insert_pct + (100 - insert_pct) / 2) begin
         send_op(KIND_FIND, key, pos, pick_value());
      end else if (roll < 96) begin
         if ($urandom_range(0, 4) != 0) pos = 5'($urandom_range(0, tbl_count));
         send_op(KIND_READ, key, pos, pick_value());
      end else begin
         send_op(KIND_UNUSED, key, pos, pick_value());
      end
   endtask

   task automatic test_directed();
      send_op(KIND_READ,   '0,            5'd0,  '0);
      send_op(KIND_FIND,   '0,            5'd0,  '1);
      send_op(KIND_UNUSED, '1,            5'd31, '1);
      send_op(KIND_INSERT, 32'h1234_5678, 5'd1,  '1);
      send_op(KIND_INSERT, 32'h8000_0000, 5'd0,  '1);
      send_op(KIND_INSERT, '0,            5'd0,  '0);
      send_op(KIND_INSERT, '1,            5'd2,  64'h5555_5555_5555_5555);
      send_op(KIND_INSERT, 32'h4000_0000, 5'd31, '1);
      send_op(KIND_INSERT, 32'h4000_0000, 5'd1,  64'hAAAA_AAAA_AAAA_AAAA);
      send_op(KIND_FIND,   '0,            5'd31, '0);
      send_op(KIND_FIND,   '1,            5'd0,  '0);
      send_op(KIND_FIND,   32'h7FFF_FFFF, 5'd0,  '0);
      send_op(KIND_FIND,   32'h4000_0000, 5'd0,  '0);
      send_op(KIND_FIND,   32'hFFFF_FFFE, 5'd0,  '0);
      send_op(KIND_READ,   '0,            5'd0,  '0);
      send_op(KIND_READ,   '1,            5'd3,  '1);
      send_op(KIND_READ,   '0,            5'd4,  '0);
      send_op(KIND_READ,   '0,            5'd31, '0);
      send_op(KIND_UNUSED, '0,            5'd0,  '0);
   endtask

   task automatic test_random_fill();
      repeat (300) random_op(6);
   endtask

   task automatic test_full_table();
      logic             hit;
      int unsigned      slot;
      logic [KEY_W-1:0] key;
      while (tbl_count < MAX_ENTRIES - 1) begin
         key = $urandom;
         search_keys(key, hit, slot);
         send_op(KIND_INSERT, key, slot[4:0], pick_value());
      end
      // last slot goes to a key out of order
      if (tbl_count == MAX_ENTRIES - 1) send_op(KIND_INSERT, 32'd1, 5'(tbl_count), '1);
      send_op(KIND_INSERT, 32'h0BAD_0BAD, 5'd31, '1);
      send_op(KIND_INSERT, 32'h0BAD_0BAD, 5'd0,  '0);
      send_op(KIND_READ,   '0,            5'd15, '0);
      send_op(KIND_READ,   '0,            5'd16, '0);
      send_op(KIND_FIND,   '0,            5'd0,  '0);
      send_op(KIND_FIND,   '1,            5'd0,  '0);
      send_op(KIND_FIND,   32'd1,         5'd0,  '0);
   endtask

   task automatic test_random_full();
      repeat (480) random_op(8);
   endtask

   always @(negedge clock) begin : rsp_stall_pattern
      static int  ready_run   = 0;
      static logic ready_phase = 1'b1;
      if (ready_run == 0) begin
         ready_phase = ~ready_phase;
         if (ready_phase) begin
            ready_run = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
         end else begin
            ready_run = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 4);
         end
      end
      ready_run--;
      rsp_tready <= ready_phase;
   end

   always @(posedge clock) begin : rsp_checker
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $error("result transfer with no request outstanding, status %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = pending_q.pop_front();
            check_field("status",      want.status,   rsp_tuser);
            check_field("found",       want.found,    rsp_tdata[0]);
            check_field("slot_index",  want.slot,     rsp_tdata[5:1]);
            check_field("read_key",    want.rd_key,   rsp_tdata[37:6]);
            check_field("read_value",  want.rd_value, rsp_tdata[101:38]);
            check_field("entry_count", want.entries,  rsp_tdata[106:102]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_key_table regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drain();
      test_random_fill();
      wait_drain();
      test_full_table();
      test_random_full();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d finds (%0d hits), %0d inserts (%0d stored), %0d reads (%0d past end),",
               n_find, n_hit, n_insert, n_insert_ok, n_read, n_read_end);
      $display("%0d unused-kind requests, final entry count %0d, %0d mismatches",
               n_unused, tbl_count, fail_count);
      if (fail_count == 0) begin
         $display("sorted_key_table regression: pass");
      end else begin
         $display("sorted_key_table regression: fail");
      end
      $finish;
   end

endmodule
